[rtl/tnhs_pkg.sv]
// Shared constants, types and helpers for the tabu ring novelty selector.
package tnhs_pkg;

	localparam int RING_DEPTH = 16;
	localparam int SIG_W      = 64;
	localparam int DIST_W     = 7;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// Ones count of one byte.
	function automatic logic [3:0] popcnt8(input logic [7:0] b);
		logic [3:0] acc;
		acc = 4'd0;
		for (int i = 0; i < 8; i++) begin
			acc = acc + {3'd0, b[i]};
		end
		return acc;
	endfunction

endpackage

[rtl/tnhs_dist_unit.sv]
// Shared Hamming distance and running-minimum unit.
module tnhs_dist_unit (
	input  logic [tnhs_pkg::SIG_W-1:0]  sig_a,
	input  logic [tnhs_pkg::SIG_W-1:0]  sig_b,
	input  logic [tnhs_pkg::DIST_W-1:0] cur_min,
	output logic [tnhs_pkg::DIST_W-1:0] new_min
);

	logic [tnhs_pkg::SIG_W-1:0]  diff;
	logic [3:0]                  byte_cnt [8];
	logic [4:0]                  sum_l1 [4];
	logic [5:0]                  sum_l2 [2];
	logic [tnhs_pkg::DIST_W-1:0] ham_dist;

	assign diff = sig_a ^ sig_b;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			byte_cnt[i] = tnhs_pkg::popcnt8(diff[8*i +: 8]);
		end
		for (int i = 0; i < 4; i++) begin
			sum_l1[i] = {1'b0, byte_cnt[2*i]} + {1'b0, byte_cnt[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			sum_l2[i] = {1'b0, sum_l1[2*i]} + {1'b0, sum_l1[2*i+1]};
		end
		ham_dist = {1'b0, sum_l2[0]} + {1'b0, sum_l2[1]};
	end

	// keep the smaller of the running minimum and this entry's distance
	assign new_min = (ham_dist < cur_min) ? ham_dist : cur_min;

endmodule

[rtl/tabu_hamming_novelty_select.sv]
// Top level of the tabu ring nearest-Hamming-distance novelty selector.
//
// The block holds a ring of tnhs_pkg::RING_DEPTH 64-bit tabu signatures.
// An insert word (tuser op = 0) writes its signature at the write pointer in
// the cycle it is accepted; the pointer wraps and the fill count saturates at
// the ring depth, so a full ring overwrites its oldest entry. A query word
// (op = 1) walks the filled entries through one ring read port and a single
// shared popcount/compare unit, one entry per cycle, to find the least
// Hamming distance (64 on an empty ring). It then updates the best candidate
// of the trial group: a first_trial query always replaces it, a later query
// only on a strictly greater distance. Each query returns one result word
// carrying the minimum, the current best distance and signature, with tlast
// set when the query was the group's last trial; inserts return nothing.
// An insert leaves s_axis_tready high; a query holds s_axis_tready low
// through the scan and update states, for a time that is set by the fill count and
// bounded by the single read port and the one distance unit. A finished
// result sits in an output register, so the next word is taken while the
// result waits for m_axis_tready; only a second query's update stalls behind
// an untaken result, for as long as the result side holds off.
module tabu_hamming_novelty_select (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] signature
	input  logic [1:0]  s_axis_tuser,  // [0] op, [1] first_trial
	input  logic        s_axis_tlast,  // last_trial
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // [6:0] min_distance, [13:7] best_distance,
	                                   // [77:14] best_signature, [79:78] zero
	output logic        m_axis_tlast   // choice_ready
);

	localparam logic [tnhs_pkg::DIST_W-1:0] DIST_MAX = tnhs_pkg::DIST_W'(tnhs_pkg::SIG_W);

	// ring storage, no reset: only entries below the fill count are read
	logic [tnhs_pkg::SIG_W-1:0] ring_mem [tnhs_pkg::RING_DEPTH];

	tnhs_pkg::state_t state_q, state_d;

	logic [tnhs_pkg::IDX_W-1:0]  wp_q;
	logic [tnhs_pkg::CNT_W-1:0]  fill_q;
	logic [tnhs_pkg::DIST_W-1:0] best_dist_q;
	logic [tnhs_pkg::SIG_W-1:0]  best_sig_q;

	// query context
	logic [tnhs_pkg::SIG_W-1:0]  qsig_q;
	logic                        qfirst_q;
	logic                        qlast_q;
	logic [tnhs_pkg::CNT_W-1:0]  issued_q;
	logic [tnhs_pkg::DIST_W-1:0] dmin_q;

	// read pipeline
	logic [tnhs_pkg::SIG_W-1:0]  rd_data_s1;
	logic                        rd_vld_s1;

	// output register
	logic                        out_vld_q;
	logic [tnhs_pkg::DIST_W-1:0] out_min_q;
	logic [tnhs_pkg::DIST_W-1:0] out_bdist_q;
	logic [tnhs_pkg::SIG_W-1:0]  out_bsig_q;
	logic                        out_last_q;

	logic                        in_fire;
	logic                        is_insert;
	logic                        issue;
	logic                        out_free;
	logic                        do_update;
	logic                        replace;
	logic [tnhs_pkg::DIST_W-1:0] unit_min;
	logic [tnhs_pkg::DIST_W-1:0] new_bdist;
	logic [tnhs_pkg::SIG_W-1:0]  new_bsig;

	assign s_axis_tready = (state_q == tnhs_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign is_insert     = (s_axis_tuser[0] == tnhs_pkg::OP_INSERT);

	// issue one ring read per cycle until every filled entry is out
	assign issue    = (state_q == tnhs_pkg::ST_SCAN) && (issued_q < fill_q);
	assign out_free = !out_vld_q || m_axis_tready;
	assign do_update = (state_q == tnhs_pkg::ST_UPDATE) && out_free;

	tnhs_dist_unit u_dist (
		.sig_a   (qsig_q),
		.sig_b   (rd_data_s1),
		.cur_min (dmin_q),
		.new_min (unit_min)
	);

	assign replace   = qfirst_q || (dmin_q > best_dist_q);
	assign new_bdist = replace ? dmin_q : best_dist_q;
	assign new_bsig  = replace ? qsig_q : best_sig_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			tnhs_pkg::ST_IDLE: begin
				if (in_fire && !is_insert) state_d = tnhs_pkg::ST_SCAN;
			end
			tnhs_pkg::ST_SCAN: begin
				// done once nothing is issued and the last read has compared
				if (!issue && !rd_vld_s1) state_d = tnhs_pkg::ST_UPDATE;
			end
			tnhs_pkg::ST_UPDATE: begin
				if (out_free) state_d = tnhs_pkg::ST_IDLE;
			end
			default: state_d = tnhs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tnhs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring write and registered read
	always_ff @(posedge clk) begin
		if (in_fire && is_insert) begin
			ring_mem[wp_q] <= s_axis_tdata;
		end
		rd_data_s1 <= ring_mem[issued_q[tnhs_pkg::IDX_W-1:0]];
	end

	// ring pointer, fill count and group best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			best_dist_q <= '0;
			best_sig_q  <= '0;
			rd_vld_s1   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (in_fire && is_insert) begin
				// advance and wrap the pointer, saturate the fill count
				if (wp_q == tnhs_pkg::IDX_W'(tnhs_pkg::RING_DEPTH - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
				if (fill_q != tnhs_pkg::CNT_W'(tnhs_pkg::RING_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (do_update) begin
				best_dist_q <= new_bdist;
				best_sig_q  <= new_bsig;
				out_vld_q   <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// query context and scan counters
	always_ff @(posedge clk) begin
		if (in_fire && !is_insert) begin
			qsig_q   <= s_axis_tdata;
			qfirst_q <= s_axis_tuser[1];
			qlast_q  <= s_axis_tlast;
			issued_q <= '0;
			dmin_q   <= DIST_MAX;
		end else begin
			if (issue) issued_q <= issued_q + 1'b1;
			if (rd_vld_s1) dmin_q <= unit_min;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (do_update) begin
			out_min_q   <= dmin_q;
			out_bdist_q <= new_bdist;
			out_bsig_q  <= new_bsig;
			out_last_q  <= qlast_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_bsig_q, out_bdist_q, out_min_q};
	assign m_axis_tlast  = out_last_q;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the tabu ring nearest-Hamming-distance selector.
`timescale 1ns / 100ps

module tb_top;

	// One input word as offered to the block.
	typedef struct {
		logic                        op;
		logic [tnhs_pkg::SIG_W-1:0]  sig;
		logic                        first;
		logic                        last;
		int unsigned                 gap;        // idle cycles before this word is offered
		bit                          wait_idle;  // hold until every pending choice has arrived
	} tabu_word_t;

	// One result word as the block should return it.
	typedef struct {
		logic [tnhs_pkg::DIST_W-1:0] min_d;
		logic [tnhs_pkg::DIST_W-1:0] best_d;
		logic [tnhs_pkg::SIG_W-1:0]  pick_sig;
		logic                        ready;
	} choice_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // [63:0] signature
	logic [1:0]  s_axis_tuser;   // [0] op, [1] first_trial
	logic        s_axis_tlast;   // last_trial
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // [6:0] min_distance, [13:7] best_distance,
	                             // [77:14] best_signature, [79:78] zero
	logic        m_axis_tlast;   // choice_ready

	tabu_word_t  pending_words[$];
	choice_t     expected_choices[$];
	int unsigned n_errors = 0;
	bit          calm = 0;       // no idling while set

	// Predictor state: own copy of the tabu ring and the group best.
	logic [tnhs_pkg::SIG_W-1:0]  tabu_ring [tnhs_pkg::RING_DEPTH];
	int unsigned                 ring_wptr = 0;
	int unsigned                 ring_fill = 0;
	logic [tnhs_pkg::DIST_W-1:0] grp_best_dist = '0;
	logic [tnhs_pkg::SIG_W-1:0]  grp_pick_sig = '0;

	tabu_hamming_novelty_select i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count differing bits of two signatures.
	function automatic int unsigned hamming64(input logic [tnhs_pkg::SIG_W-1:0] a,
	                                          input logic [tnhs_pkg::SIG_W-1:0] b);
		logic [tnhs_pkg::SIG_W-1:0] x;
		int unsigned                n;
		x = a ^ b;
		n = 0;
		for (int i = 0; i < tnhs_pkg::SIG_W; i++) begin
			n += x[i];
		end
		return n;
	endfunction

	// Apply one accepted word to the predictor; queue the choice a query returns.
	function automatic void predict_novelty(input tabu_word_t w);
		int unsigned dmin;
		int unsigned d;
		choice_t     c;
		if (w.op == tnhs_pkg::OP_INSERT) begin
			// write at the pointer, wrap, saturate the fill count; flags are ignored
			tabu_ring[ring_wptr] = w.sig;
			ring_wptr = (ring_wptr + 1 >= tnhs_pkg::RING_DEPTH) ? 0 : ring_wptr + 1;
			if (ring_fill < tnhs_pkg::RING_DEPTH)
				ring_fill++;
			return;
		end
		dmin = tnhs_pkg::SIG_W;
		for (int i = 0; i < ring_fill; i++) begin
			d = hamming64(w.sig, tabu_ring[i]);
			if (d < dmin)
				dmin = d;
		end
		// a first trial always wins, a later one only on a strictly greater distance
		if (w.first || dmin > grp_best_dist) begin
			grp_best_dist = dmin[tnhs_pkg::DIST_W-1:0];
			grp_pick_sig = w.sig;
		end
		c.min_d = dmin[tnhs_pkg::DIST_W-1:0];
		c.best_d = grp_best_dist;
		c.pick_sig = grp_pick_sig;
		c.ready = w.last;
		expected_choices.push_back(c);
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_idle();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_word(input logic op, input logic [tnhs_pkg::SIG_W-1:0] sig,
	                        input logic first, input logic last, input bit wait_idle);
		tabu_word_t w;
		w.op = op;
		w.sig = sig;
		w.first = first;
		w.last = last;
		w.gap = pick_idle();
		w.wait_idle = wait_idle;
		pending_words.push_back(w);
	endtask

	// ---------------------------------------------------------------- driver
	tabu_word_t  cur_word;
	int unsigned tx_gap = 0;
	bit          tx_gap_armed = 0;
	bit          tx_valid_nxt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			s_axis_tlast <= 1'b0;
			tx_gap = 0;
			tx_gap_armed = 0;
		end else begin
			tx_valid_nxt = s_axis_tvalid;
			// retire the word taken at this edge
			if (s_axis_tvalid && s_axis_tready) begin
				predict_novelty(cur_word);
				tx_valid_nxt = 1'b0;
			end
			if (!tx_valid_nxt && pending_words.size() > 0) begin
				if (!tx_gap_armed) begin
					tx_gap = pending_words[0].gap;
					tx_gap_armed = 1;
				end
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (!pending_words[0].wait_idle || expected_choices.size() == 0) begin
					// offer the next word; a pausing word waits for the result side to drain
					cur_word = pending_words.pop_front();
					tx_gap_armed = 0;
					tx_valid_nxt = 1'b1;
					s_axis_tdata <= cur_word.sig;
					s_axis_tuser <= {cur_word.first, cur_word.op};
					s_axis_tlast <= cur_word.last;
				end
			end
			s_axis_tvalid <= tx_valid_nxt;
		end
	end

	// ------------------------------------------- long receiver hold-off
	// After a few hundred words are in, block the result side for a long
	// stretch so the output register fills and the input stalls.
	int unsigned rx_hold_left = 0;
	int unsigned words_in = 0;
	bit          rx_hold_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
			words_in <= 0;
			rx_hold_done <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				words_in <= words_in + 1;
			if (!rx_hold_done && words_in >= 600) begin
				rx_hold_left <= 400;
				rx_hold_done <= 1;
			end else if (rx_hold_left > 0) begin
				rx_hold_left <= rx_hold_left - 1;
			end
		end
	end

	// --------------------------------------------------------------- monitor
	task automatic report_field(input string name, input logic [tnhs_pkg::SIG_W-1:0] exp_v,
	                            input logic [tnhs_pkg::SIG_W-1:0] act_v);
		$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
		n_errors++;
	endtask

	choice_t     exp_c;
	int unsigned rx_stall = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_choices.size() == 0) begin
					$display("%0t: result word with none expected: tdata %0h tlast %0b",
					         $time, m_axis_tdata, m_axis_tlast);
					n_errors++;
				end else begin
					exp_c = expected_choices.pop_front();
					if (m_axis_tdata[6:0] !== exp_c.min_d)
						report_field("min_distance", tnhs_pkg::SIG_W'(exp_c.min_d),
						             tnhs_pkg::SIG_W'(m_axis_tdata[6:0]));
					if (m_axis_tdata[13:7] !== exp_c.best_d)
						report_field("best_distance", tnhs_pkg::SIG_W'(exp_c.best_d),
						             tnhs_pkg::SIG_W'(m_axis_tdata[13:7]));
					if (m_axis_tdata[77:14] !== exp_c.pick_sig)
						report_field("best_signature", exp_c.pick_sig, m_axis_tdata[77:14]);
					if (m_axis_tlast !== exp_c.ready)
						report_field("choice_ready", tnhs_pkg::SIG_W'(exp_c.ready),
						             tnhs_pkg::SIG_W'(m_axis_tlast));
				end
				rx_stall = pick_idle();
			end else if (!m_axis_tvalid && rx_stall == 0 && $urandom_range(0, 7) == 0) begin
				// drop ready now and then while nothing is offered
				rx_stall = pick_idle();
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (rx_hold_left == 0);
			end
		end
	end

	// -------------------------------------------------------------- stimulus
	initial begin
		logic [tnhs_pkg::SIG_W-1:0] recent [tnhs_pkg::RING_DEPTH];
		logic [tnhs_pkg::SIG_W-1:0] sig;
		int unsigned                n_recent;
		int unsigned                n_words;
		int unsigned                r;
		int unsigned                len;
		int unsigned                flips;
		bit                         idle_wait;

		arst_n = 1'b0;
		n_recent = 0;
		n_words = 0;

		// Directed part.
		// Query with no first trial against the reset best, on an empty ring.
		add_word(tnhs_pkg::OP_QUERY, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b0, 1'b0);
		// Empty ring, first trial restarts the group.
		add_word(tnhs_pkg::OP_QUERY, 64'h0, 1'b1, 1'b0, 1'b0);
		// Equal distance does not replace the best.
		add_word(tnhs_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0);
		// Insert flags are ignored.
		add_word(tnhs_pkg::OP_INSERT, 64'h0, 1'b1, 1'b1, 1'b0);
		add_word(tnhs_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0);
		add_word(tnhs_pkg::OP_QUERY, 64'h0, 1'b0, 1'b1, 1'b0);
		add_word(tnhs_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0);
		add_word(tnhs_pkg::OP_QUERY, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0);
		add_word(tnhs_pkg::OP_QUERY, 64'h8000_0000_0000_0001, 1'b0, 1'b1, 1'b0);
		add_word(tnhs_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0);
		add_word(tnhs_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0);
		// Fill past the ring depth so the pointer wraps and the oldest is lost.
		for (int i = 0; i < tnhs_pkg::RING_DEPTH; i++) begin
			add_word(tnhs_pkg::OP_INSERT, 64'h1 << (i * 4), 1'b0, 1'b0, 1'b0);
		end
		// Full ring; the first query waits until the result side is drained.
		add_word(tnhs_pkg::OP_QUERY, 64'h0, 1'b1, 1'b0, 1'b1);
		add_word(tnhs_pkg::OP_QUERY, 64'hFFFF_0000_FFFF_0000, 1'b0, 1'b1, 1'b0);
		n_words = pending_words.size();
		for (int i = 0; i < tnhs_pkg::RING_DEPTH; i++) begin
			recent[i] = 64'h1 << (i * 4);
		end
		n_recent = tnhs_pkg::RING_DEPTH;

		// Random part: mostly well-formed trial groups near stored signatures.
		while (n_words < 1300) begin
			if ($urandom_range(0, 59) == 0)
				calm = ~calm;
			idle_wait = ($urandom_range(0, 39) == 0);
			r = $urandom_range(0, 99);
			if (r < 25) begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++) begin
					sig = {$urandom(), $urandom()};
					if (n_recent > 0 && $urandom_range(0, 2) == 0) begin
						sig = recent[$urandom_range(0, n_recent - 1)];
						flips = $urandom_range(1, 12);
						for (int k = 0; k < flips; k++) begin
							sig[$urandom_range(0, tnhs_pkg::SIG_W - 1)] ^= 1'b1;
						end
					end
					recent[n_recent % tnhs_pkg::RING_DEPTH] = sig;
					n_recent = (n_recent < tnhs_pkg::RING_DEPTH) ? n_recent + 1
					                                              : tnhs_pkg::RING_DEPTH;
					add_word(tnhs_pkg::OP_INSERT, sig, 1'($urandom_range(0, 1)),
					         1'($urandom_range(0, 1)), (i == 0) ? idle_wait : 1'b0);
				end
				n_words += len;
			end else if (r < 85) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					sig = {$urandom(), $urandom()};
					if (n_recent > 0 && $urandom_range(0, 9) < 7) begin
						sig = recent[$urandom_range(0, n_recent - 1)];
						flips = $urandom_range(0, 20);
						for (int k = 0; k < flips; k++) begin
							sig[$urandom_range(0, tnhs_pkg::SIG_W - 1)] ^= 1'b1;
						end
					end
					add_word(tnhs_pkg::OP_QUERY, sig, (i == 0), (i == len - 1),
					         (i == 0) ? idle_wait : 1'b0);
				end
				n_words += len;
			end else begin
				// broken groups: query flags at random
				add_word(tnhs_pkg::OP_QUERY, {$urandom(), $urandom()},
				         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), idle_wait);
				n_words++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_choices.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#10000000;
		$display("%0t: timeout, %0d results still expected", $time, expected_choices.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
